FILE: rtl/hbsa_pkg.sv
package hbsa_pkg;

  localparam int unsigned MaxSlots = 32768;
  localparam int unsigned BinBits  = 32;
  localparam int unsigned LeafBins = (MaxSlots + BinBits - 1) / BinBits;
  localparam int unsigned MidBins  = (LeafBins + BinBits - 1) / BinBits;
  localparam int unsigned SlotW    = 15;
  localparam int unsigned TotW     = 16;
  localparam int unsigned BinW     = 10;
  localparam int unsigned MidW     = 5;
  localparam int unsigned BitW     = 5;
  localparam int unsigned MidCntW  = 11;
  localparam int unsigned PopW     = 6;

  typedef enum logic [1:0] {
    MODE_USE   = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD,
    S_SCAN,
    S_FREE_RD,
    S_FREE_GET,
    S_USED_RD,
    S_USED_GET,
    S_NTH_RD,
    S_NTH_CHK,
    S_NTH_SEL,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_UPD,
    OP_SCAN,
    OP_FREE_RD,
    OP_FREE_GET,
    OP_USED_RD,
    OP_USED_GET,
    OP_NTH_RD,
    OP_NTH_CHK,
    OP_NTH_SEL
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic clr_last;
    logic scan_last;
    logic nth_want;
    logic nth_hit;
    logic k_zero;
  } status_t;

endpackage

FILE: rtl/hierarchical_bitmap_slot_allocator.sv
// channel   | handshake               | signals
// request   | start & !busy           | mode_i, slot_index_i, rank_i
// result    | done_o (one cycle)      | slot_was_used_o .. nth_found_o
// config    | num_slots_we_i          | num_slots_i
//
// done_o follows the update, the scan over all mid bins and the first-free and first-used
// reads; a rank search adds a walk over the leaf bins of one mid bin (up to 32) and a
// select that drops k used bits (k up to 31), paced by the single leaf memory read port
// and the one-mid-bin scan. After reset and after every num_slots write a clearing pass
// over all leaf bins runs with busy high. Results are valid only in the done_o cycle; the
// receiver cannot stall, and the next request is taken in the cycle after done_o.
module hierarchical_bitmap_slot_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        num_slots_we_i,
  input  logic [15:0] num_slots_i,
  input  logic [1:0]  mode_i,
  input  logic [14:0] slot_index_i,
  input  logic [14:0] rank_i,
  output logic        done_o,
  output logic        slot_was_used_o,
  output logic [15:0] used_total_o,
  output logic [14:0] first_free_slot_o,
  output logic        free_found_o,
  output logic [14:0] first_used_slot_o,
  output logic        used_found_o,
  output logic [14:0] nth_used_slot_o,
  output logic        nth_found_o
);

  hbsa_pkg::cmd_t    cmd;
  hbsa_pkg::status_t status;

  hbsa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  hbsa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (num_slots_we_i),
    .cfg_data_i        (num_slots_i),
    .mode_i            (mode_i),
    .slot_index_i      (slot_index_i),
    .rank_i            (rank_i),
    .slot_was_used_o   (slot_was_used_o),
    .used_total_o      (used_total_o),
    .first_free_slot_o (first_free_slot_o),
    .free_found_o      (free_found_o),
    .first_used_slot_o (first_used_slot_o),
    .used_found_o      (used_found_o),
    .nth_used_slot_o   (nth_used_slot_o),
    .nth_found_o       (nth_found_o)
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe while idle");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_used_cons: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (used_found_o == (used_total_o != 16'd0)))
    else $error("used flag disagrees with total");

  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    num_slots_we_i |=> busy) else $error("no clearing pass after num_slots write");

endmodule

FILE: rtl/hbsa_ctrl.sv
module hbsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  hbsa_pkg::status_t status_i,
  output hbsa_pkg::cmd_t    cmd_o,
  output logic              busy,
  output logic              done_o
);

  hbsa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hbsa_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = hbsa_pkg::OP_NOP;
    done_o    = 1'b0;
    unique case (state_q)
      hbsa_pkg::S_CLEAR: begin
        cmd_o.op = hbsa_pkg::OP_CLEAR;
        if (status_i.clr_last) state_d = hbsa_pkg::S_IDLE;
      end
      hbsa_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.op = hbsa_pkg::OP_LOAD;
          state_d  = hbsa_pkg::S_UPD;
        end
      end
      hbsa_pkg::S_UPD: begin
        cmd_o.op = hbsa_pkg::OP_UPD;
        state_d  = hbsa_pkg::S_SCAN;
      end
      hbsa_pkg::S_SCAN: begin
        cmd_o.op = hbsa_pkg::OP_SCAN;
        if (status_i.scan_last) state_d = hbsa_pkg::S_FREE_RD;
      end
      hbsa_pkg::S_FREE_RD: begin
        cmd_o.op = hbsa_pkg::OP_FREE_RD;
        state_d  = hbsa_pkg::S_FREE_GET;
      end
      hbsa_pkg::S_FREE_GET: begin
        cmd_o.op = hbsa_pkg::OP_FREE_GET;
        state_d  = hbsa_pkg::S_USED_RD;
      end
      hbsa_pkg::S_USED_RD: begin
        cmd_o.op = hbsa_pkg::OP_USED_RD;
        state_d  = hbsa_pkg::S_USED_GET;
      end
      hbsa_pkg::S_USED_GET: begin
        cmd_o.op = hbsa_pkg::OP_USED_GET;
        state_d  = status_i.nth_want ? hbsa_pkg::S_NTH_RD : hbsa_pkg::S_DONE;
      end
      hbsa_pkg::S_NTH_RD: begin
        cmd_o.op = hbsa_pkg::OP_NTH_RD;
        state_d  = hbsa_pkg::S_NTH_CHK;
      end
      hbsa_pkg::S_NTH_CHK: begin
        cmd_o.op = hbsa_pkg::OP_NTH_CHK;
        state_d  = status_i.nth_hit ? hbsa_pkg::S_NTH_SEL : hbsa_pkg::S_NTH_RD;
      end
      hbsa_pkg::S_NTH_SEL: begin
        cmd_o.op = hbsa_pkg::OP_NTH_SEL;
        if (status_i.k_zero) state_d = hbsa_pkg::S_DONE;
      end
      hbsa_pkg::S_DONE: begin
        done_o  = 1'b1;
        state_d = hbsa_pkg::S_IDLE;
      end
      default: state_d = hbsa_pkg::S_CLEAR;
    endcase
    // a num_slots write restarts the clearing pass
    if (status_i.cfg_wr) state_d = hbsa_pkg::S_CLEAR;
  end

  assign busy = (state_q != hbsa_pkg::S_IDLE);

endmodule

FILE: rtl/hbsa_dp.sv
module hbsa_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hbsa_pkg::cmd_t    cmd_i,
  output hbsa_pkg::status_t status_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_data_i,
  input  logic [1:0]        mode_i,
  input  logic [14:0]       slot_index_i,
  input  logic [14:0]       rank_i,
  output logic              slot_was_used_o,
  output logic [15:0]       used_total_o,
  output logic [14:0]       first_free_slot_o,
  output logic              free_found_o,
  output logic [14:0]       first_used_slot_o,
  output logic              used_found_o,
  output logic [14:0]       nth_used_slot_o,
  output logic              nth_found_o
);

  localparam int unsigned BinBits = hbsa_pkg::BinBits;
  localparam int unsigned BinW    = hbsa_pkg::BinW;
  localparam int unsigned MidW    = hbsa_pkg::MidW;
  localparam int unsigned BitW    = hbsa_pkg::BitW;
  localparam int unsigned TotW    = hbsa_pkg::TotW;
  localparam int unsigned SlotW   = hbsa_pkg::SlotW;
  localparam int unsigned PopW    = hbsa_pkg::PopW;
  localparam int unsigned MidCntW = hbsa_pkg::MidCntW;

  function automatic logic [BitW-1:0] lowest(logic [BinBits-1:0] w);
    logic [BitW-1:0] r;
    r = '0;
    for (int i = BinBits - 1; i >= 0; i--) begin
      if (w[i]) r = BitW'(i);
    end
    return r;
  endfunction

  function automatic logic [PopW-1:0] popcount(logic [BinBits-1:0] w);
    logic [PopW-1:0] r;
    r = '0;
    for (int i = 0; i < BinBits; i++) begin
      r = r + PopW'(w[i]);
    end
    return r;
  endfunction

  function automatic logic [BinBits-1:0] low_mask(logic [PopW-1:0] k);
    logic [BinBits-1:0] r;
    r = k[PopW-1] ? '1 : ((BinBits'(1) << k[BitW-1:0]) - BinBits'(1));
    return r;
  endfunction

  function automatic logic [PopW-1:0] valid_in_bin(logic [BinW-1:0] bin,
                                                   logic [TotW-1:0] n);
    logic [TotW-1:0] start, diff;
    logic [PopW-1:0] r;
    start = {1'b0, bin, {BitW{1'b0}}};
    diff  = n - start;
    if (start >= n) r = '0;
    else if (diff >= TotW'(BinBits)) r = PopW'(BinBits);
    else r = diff[PopW-1:0];
    return r;
  endfunction

  // leaf bins holding no valid slot read as full
  function automatic logic [BinBits-1:0] beyond(logic [MidW-1:0] m, logic [BinW:0] nb);
    logic [BinBits-1:0] r;
    logic [MidW:0] nbh;
    nbh = nb[BinW:BitW];
    if ({1'b0, m} < nbh) r = '0;
    else if ({1'b0, m} > nbh) r = '1;
    else r = ~((BinBits'(1) << nb[BitW-1:0]) - BinBits'(1));
    return r;
  endfunction

  logic [BinBits-1:0] leaf_mem [hbsa_pkg::LeafBins];
  logic [BinBits-1:0] rdata_q;
  logic [BinW-1:0]    raddr, waddr;
  logic [BinBits-1:0] wdata;
  logic               we;

  logic [BinBits-1:0] any_q  [hbsa_pkg::MidBins];
  logic [BinBits-1:0] full_q [hbsa_pkg::MidBins];
  logic [MidCntW-1:0] mcnt_q [hbsa_pkg::MidBins];
  logic [TotW-1:0]    total_q, n_q;
  logic [BinW-1:0]    clr_q;

  logic [1:0]         mode_q;
  logic [SlotW-1:0]   idx_q, rank_q;
  logic [MidW-1:0]    m_q, nmid_q, lb_q;
  logic               fsel_q, usel_q, nf_q;
  logic [BinW-1:0]    fbin_q, ubin_q;
  logic [TotW-1:0]    acc_q;
  logic [BinBits-1:0] w_q;
  logic [BitW-1:0]    k_q;

  logic               was_q, ffound_q, ufound_q, nfound_q;
  logic [SlotW-1:0]   ff_q, fu_q, nth_q;

  logic [TotW-1:0]    n_eff;
  logic [BinW:0]      nb;
  logic [BinW-1:0]    upd_bin;
  logic [MidW-1:0]    upd_mid, upd_j, msel;
  logic [BitW-1:0]    upd_bit;
  logic               in_rng, was, do_set, do_clr;
  logic [BinBits-1:0] bitmask, new_word, free_w;
  logic [PopW-1:0]    new_pop, rd_pop;
  logic [MidCntW-1:0] mcnt_rd;
  logic [BinBits-1:0] full_rd, any_rd;
  logic [TotW-1:0]    sum_m, sum_b, rank_left;
  logic               nth_hit;

  always_comb begin
    n_eff    = (n_q > TotW'(hbsa_pkg::MaxSlots)) ? TotW'(hbsa_pkg::MaxSlots) : n_q;
    nb       = (BinW + 1)'(({1'b0, n_eff} + (TotW + 1)'(BinBits - 1)) >> BitW);
    upd_bin  = idx_q[SlotW-1:BitW];
    upd_mid  = idx_q[SlotW-1:BitW+BinW-MidW];
    upd_j    = idx_q[BitW+MidW-1:BitW];
    upd_bit  = idx_q[BitW-1:0];
    in_rng   = ({1'b0, idx_q} < n_eff);
    was      = in_rng & rdata_q[upd_bit];
    do_set   = in_rng && (mode_q == hbsa_pkg::MODE_USE) && !was;
    do_clr   = in_rng && (mode_q == hbsa_pkg::MODE_FREE) && was;
    bitmask  = BinBits'(1) << upd_bit;
    new_word = do_set ? (rdata_q | bitmask) : (rdata_q & ~bitmask);
    new_pop  = popcount(new_word);
    rd_pop   = popcount(rdata_q);

    msel     = (cmd_i.op == hbsa_pkg::OP_UPD) ? upd_mid : m_q;
    mcnt_rd  = mcnt_q[msel];
    full_rd  = full_q[msel];
    any_rd   = any_q[msel];
    free_w   = ~(full_rd | beyond(m_q, nb));
    sum_m    = acc_q + TotW'(mcnt_rd);
    sum_b    = acc_q + TotW'(rd_pop);
    rank_left = TotW'(rank_q) - acc_q;
    nth_hit  = (sum_b > TotW'(rank_q));

    we    = 1'b0;
    waddr = upd_bin;
    wdata = new_word;
    if (cmd_i.op == hbsa_pkg::OP_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else if (cmd_i.op == hbsa_pkg::OP_UPD) begin
      we = do_set | do_clr;
    end

    case (cmd_i.op)
      hbsa_pkg::OP_LOAD:    raddr = slot_index_i[SlotW-1:BitW];
      hbsa_pkg::OP_FREE_RD: raddr = fbin_q;
      hbsa_pkg::OP_USED_RD: raddr = ubin_q;
      hbsa_pkg::OP_NTH_RD:  raddr = {nmid_q, lb_q};
      default:              raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) leaf_mem[waddr] <= wdata;
    rdata_q <= leaf_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= TotW'(hbsa_pkg::MaxSlots);
      total_q  <= '0;
      clr_q    <= '0;
      for (int i = 0; i < hbsa_pkg::MidBins; i++) begin
        any_q[i]  <= '0;
        full_q[i] <= '0;
        mcnt_q[i] <= '0;
      end
      m_q      <= '0;
      fsel_q   <= 1'b0;
      usel_q   <= 1'b0;
      nf_q     <= 1'b0;
      k_q      <= '0;
      ffound_q <= 1'b0;
      ufound_q <= 1'b0;
      nfound_q <= 1'b0;
      was_q    <= 1'b0;
    end else if (cfg_we_i) begin
      n_q     <= cfg_data_i;
      total_q <= '0;
      clr_q   <= '0;
      for (int i = 0; i < hbsa_pkg::MidBins; i++) begin
        any_q[i]  <= '0;
        full_q[i] <= '0;
        mcnt_q[i] <= '0;
      end
    end else begin
      case (cmd_i.op)
        hbsa_pkg::OP_CLEAR: clr_q <= clr_q + BinW'(1);
        hbsa_pkg::OP_LOAD: begin
          mode_q   <= mode_i;
          idx_q    <= slot_index_i;
          rank_q   <= rank_i;
          m_q      <= '0;
          lb_q     <= '0;
          acc_q    <= '0;
          fsel_q   <= 1'b0;
          usel_q   <= 1'b0;
          nf_q     <= 1'b0;
          ff_q     <= '0;
          fu_q     <= '0;
          nth_q    <= '0;
          ffound_q <= 1'b0;
          ufound_q <= 1'b0;
          nfound_q <= 1'b0;
        end
        hbsa_pkg::OP_UPD: begin
          was_q <= was;
          if (do_set) begin
            mcnt_q[upd_mid] <= mcnt_rd + MidCntW'(1);
            total_q         <= total_q + TotW'(1);
            any_q[upd_mid][upd_j] <= 1'b1;
            if (new_pop == valid_in_bin(upd_bin, n_eff)) full_q[upd_mid][upd_j] <= 1'b1;
          end else if (do_clr) begin
            mcnt_q[upd_mid] <= mcnt_rd - MidCntW'(1);
            total_q         <= total_q - TotW'(1);
            full_q[upd_mid][upd_j] <= 1'b0;
            if (new_word == '0) any_q[upd_mid][upd_j] <= 1'b0;
          end
        end
        hbsa_pkg::OP_SCAN: begin
          m_q <= m_q + MidW'(1);
          if (!fsel_q && free_w != '0) begin
            fsel_q <= 1'b1;
            fbin_q <= {m_q, lowest(free_w)};
          end
          if (!usel_q && any_rd != '0) begin
            usel_q <= 1'b1;
            ubin_q <= {m_q, lowest(any_rd)};
          end
          if (!nf_q) begin
            if (sum_m > TotW'(rank_q)) begin
              nf_q   <= 1'b1;
              nmid_q <= m_q;
            end else begin
              acc_q <= sum_m;
            end
          end
        end
        hbsa_pkg::OP_FREE_GET: begin
          if (fsel_q) begin
            ffound_q <= 1'b1;
            ff_q <= {fbin_q, lowest(~rdata_q & low_mask(valid_in_bin(fbin_q, n_eff)))};
          end
        end
        hbsa_pkg::OP_USED_GET: begin
          if (usel_q) begin
            ufound_q <= 1'b1;
            fu_q     <= {ubin_q, lowest(rdata_q)};
          end
        end
        hbsa_pkg::OP_NTH_CHK: begin
          if (nth_hit) begin
            w_q <= rdata_q;
            k_q <= rank_left[BitW-1:0];
          end else begin
            acc_q <= sum_b;
            lb_q  <= lb_q + MidW'(1);
          end
        end
        hbsa_pkg::OP_NTH_SEL: begin
          if (k_q == '0) begin
            nfound_q <= 1'b1;
            nth_q    <= {nmid_q, lb_q, lowest(w_q)};
          end else begin
            // drop the lowest used bit
            w_q <= w_q & (w_q - BinBits'(1));
            k_q <= k_q - BitW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status_o.cfg_wr    = cfg_we_i;
    status_o.clr_last  = (clr_q == '1);
    status_o.scan_last = (m_q == '1);
    status_o.nth_want  = nf_q;
    status_o.nth_hit   = nth_hit;
    status_o.k_zero    = (k_q == '0);
  end

  assign slot_was_used_o   = was_q;
  assign used_total_o      = total_q;
  assign first_free_slot_o = ff_q;
  assign free_found_o      = ffound_q;
  assign first_used_slot_o = fu_q;
  assign used_found_o      = ufound_q;
  assign nth_used_slot_o   = nth_q;
  assign nth_found_o       = nfound_q;

endmodule

FILE: verif/hbsa_checker.sv
`timescale 1ns / 1ps

module hbsa_checker
  import hbsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic        num_slots_we_i,
  input  logic [15:0] num_slots_i,
  input  logic [1:0]  mode_i,
  input  logic [14:0] slot_index_i,
  input  logic [14:0] rank_i,
  input  logic        done_o,
  input  logic        slot_was_used_o,
  input  logic [15:0] used_total_o,
  input  logic [14:0] first_free_slot_o,
  input  logic        free_found_o,
  input  logic [14:0] first_used_slot_o,
  input  logic        used_found_o,
  input  logic [14:0] nth_used_slot_o,
  input  logic        nth_found_o,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic             was_used;
    logic [TotW-1:0]  total;
    logic [SlotW-1:0] free_slot;
    logic             free_hit;
    logic [SlotW-1:0] used_slot;
    logic             used_hit;
    logic [SlotW-1:0] nth_slot;
    logic             nth_hit;
  } alloc_res_t;

  logic [BinBits-1:0] slot_words [LeafBins];
  int unsigned        live_slots;
  int unsigned        used_count;
  alloc_res_t         alloc_q[$];
  int                 fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = alloc_q.size();

  function automatic int unsigned bin_span(int unsigned b);
    int unsigned lo;
    lo = b * BinBits;
    if (lo >= live_slots) return 0;
    return (live_slots - lo >= BinBits) ? BinBits : live_slots - lo;
  endfunction

  function automatic void clear_slots(int unsigned n);
    live_slots = (n > MaxSlots) ? MaxSlots : n;
    used_count = 0;
    foreach (slot_words[b]) slot_words[b] = '0;
  endfunction

  function automatic alloc_res_t allocate(logic [1:0] mode, int unsigned idx,
                                          int unsigned rank);
    alloc_res_t  r;
    int unsigned b, bit_pos, span, acc, k, cnt;
    logic [BinBits-1:0] w;
    r = '0;
    if (idx < live_slots) begin
      b = idx / BinBits;
      bit_pos = idx % BinBits;
      r.was_used = slot_words[b][bit_pos];
      if (mode == MODE_USE && !r.was_used) begin
        slot_words[b][bit_pos] = 1'b1;
        used_count++;
      end else if (mode == MODE_FREE && r.was_used) begin
        slot_words[b][bit_pos] = 1'b0;
        used_count--;
      end
    end
    r.total = TotW'(used_count);
    for (b = 0; b < LeafBins; b++) begin
      span = bin_span(b);
      if (span == 0) break;
      w = ~slot_words[b];
      if (span < BinBits) w &= BinBits'((1 << span) - 1);
      if (w != 0) begin
        for (k = 0; k < BinBits; k++)
          if (w[k]) break;
        r.free_slot = SlotW'(b * BinBits + k);
        r.free_hit  = 1'b1;
        break;
      end
    end
    for (b = 0; b < LeafBins; b++) begin
      if (slot_words[b] != 0) begin
        for (k = 0; k < BinBits; k++)
          if (slot_words[b][k]) break;
        r.used_slot = SlotW'(b * BinBits + k);
        r.used_hit  = 1'b1;
        break;
      end
    end
    if (rank < used_count) begin
      acc = 0;
      for (b = 0; b < LeafBins; b++) begin
        cnt = $countones(slot_words[b]);
        if (acc + cnt > rank) begin
          k = rank - acc;
          for (bit_pos = 0; bit_pos < BinBits; bit_pos++) begin
            if (slot_words[b][bit_pos]) begin
              if (k == 0) break;
              k--;
            end
          end
          r.nth_slot = SlotW'(b * BinBits + bit_pos);
          r.nth_hit  = 1'b1;
          break;
        end
        acc += cnt;
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp, logic [15:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp, act);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_res_t exp;
    if (!rst_ni) begin
      clear_slots(MaxSlots);
      alloc_q.delete();
      fail_count = 0;
    end else begin
      if (done_o) begin
        if (alloc_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          exp = alloc_q.pop_front();
          check_field("slot_was_used", exp.was_used, slot_was_used_o);
          check_field("used_total", exp.total, used_total_o);
          check_field("first_free_slot", exp.free_slot, first_free_slot_o);
          check_field("free_found", exp.free_hit, free_found_o);
          check_field("first_used_slot", exp.used_slot, first_used_slot_o);
          check_field("used_found", exp.used_hit, used_found_o);
          check_field("nth_used_slot", exp.nth_slot, nth_used_slot_o);
          check_field("nth_found", exp.nth_hit, nth_found_o);
        end
      end
      if (num_slots_we_i) clear_slots(num_slots_i);
      if (start && !busy) alloc_q.push_back(allocate(mode_i, slot_index_i, rank_i));
    end
  end

endmodule

FILE: verif/tb_hierarchical_bitmap_slot_allocator.sv
`timescale 1ns / 1ps

module tb_hierarchical_bitmap_slot_allocator;
  import hbsa_pkg::*;

  localparam logic [1:0] ModeSpare = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        num_slots_we_i = 1'b0;
  logic [15:0] num_slots_i = '0;
  logic [1:0]  mode_i = MODE_QUERY;
  logic [14:0] slot_index_i = '0;
  logic [14:0] rank_i = '0;
  logic        done_o, slot_was_used_o, free_found_o, used_found_o, nth_found_o;
  logic [15:0] used_total_o;
  logic [14:0] first_free_slot_o, first_used_slot_o, nth_used_slot_o;
  int          fail_count, pending;
  int          requests_sent = 0;
  int          settings_used = 1;
  bit          no_gaps = 0;

  always #5 clk_i = ~clk_i;

  hierarchical_bitmap_slot_allocator dut (.*);

  hbsa_checker chk (.*, .fail_count_o(fail_count), .pending_o(pending));

  task automatic send_request(logic [1:0] mode, int unsigned idx, int unsigned rank,
                              bit keep);
    int gap, r;
    start        <= 1'b1;
    mode_i       <= mode;
    slot_index_i <= idx[14:0];
    rank_i       <= rank[14:0];
    do @(posedge clk_i); while (busy);
    requests_sent++;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 40) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 4);
    else gap = $urandom_range(20, 80);
    if (gap > 0 || !keep) start <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic write_slot_count(logic [15:0] value);
    wait (pending == 0);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    num_slots_we_i <= 1'b1;
    num_slots_i    <= value;
    @(posedge clk_i);
    num_slots_we_i <= 1'b0;
    // wait for the clearing pass to begin
    do @(posedge clk_i); while (!busy);
    settings_used++;
  endtask

  task automatic random_phase(int unsigned count_value, int items);
    int unsigned live, window, base, idx, rank, r;
    logic [1:0]  mode;
    live   = (count_value > MaxSlots) ? MaxSlots : count_value;
    window = (live == 0) ? 1 : ((live < 96) ? live : 96);
    for (int i = 0; i < items; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      mode = (r < 45) ? MODE_USE : (r < 75) ? MODE_FREE : (r < 95) ? MODE_QUERY : ModeSpare;
      base = ($urandom_range(0, 3) == 0 && live > window) ? live - window : 0;
      r = $urandom_range(0, 99);
      if (r < 80) idx = base + $urandom_range(0, window - 1);
      else if (r < 90) idx = $urandom_range(0, 32767);
      else idx = (live == 0) ? 0 : live - 1 + $urandom_range(0, 2);
      if (idx > 32767) idx = 32767;
      rank = ($urandom_range(0, 3) != 0) ? $urandom_range(0, window) : $urandom_range(0, 32767);
      send_request(mode, idx, rank, i != items - 1);
    end
    no_gaps = 0;
  endtask

  initial begin
    int unsigned counts[] = '{1, 0, 33, 64, 100, 65535, 40000, 32768, 200, 31, 32};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, no-op marks, spare mode, rank corners
    send_request(MODE_QUERY, 0, 0, 1);
    send_request(MODE_USE, 0, 0, 1);
    send_request(MODE_USE, 32767, 1, 1);
    send_request(MODE_USE, 32767, 1, 1);
    send_request(MODE_FREE, 5, 0, 1);
    send_request(MODE_USE, 31, 2, 1);
    send_request(MODE_USE, 32, 2, 1);
    send_request(MODE_USE, 1, 3, 1);
    send_request(ModeSpare, 32767, 32767, 1);
    send_request(MODE_QUERY, 21845, 3, 1);
    send_request(MODE_FREE, 0, 0, 1);
    send_request(MODE_FREE, 0, 4, 1);
    send_request(MODE_QUERY, 10922, 32767, 1);
    send_request(MODE_FREE, 32767, 2, 0);

    foreach (counts[c]) begin
      write_slot_count(counts[c]);
      random_phase(counts[c], 100);
    end

    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    $display("Ran %0d requests over %0d slot-count settings (0 to 65535),", requests_sent,
             settings_used);
    $display("marking, freeing and querying with in- and out-of-range slots and ranks.");
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
